FILE: src/wdc_pkg.sv
// ----------------------------------------------------------------------------
// wdc_pkg: shared constants of the waypoint drive command unit
// widths of the shared datapath, status and register codes, register reset values and the cordic angle table
// ----------------------------------------------------------------------------
package wdc_pkg;

	localparam int CORDIC_STEPS_DEF = 16;

	// datapath widths
	localparam int MUL_W  = 35;  // multiplier operand
	localparam int PROD_W = 70;  // multiplier product
	localparam int RAD_W  = 66;  // square root radicand
	localparam int ROOT_W = 34;  // square root result
	localparam int XY_W   = 54;  // heading vector components
	localparam int CRD_W  = 57;  // cordic working registers
	localparam int ANG_W  = 17;  // angle, Q3.13 with headroom

	// quarter turn in Q3.13
	localparam int HALF_PI = 12868;

	// status codes
	localparam logic [1:0] ST_DRIVE = 2'd0;
	localparam logic [1:0] ST_VAR   = 2'd1;
	localparam logic [1:0] ST_NOTGT = 2'd2;
	localparam logic [1:0] ST_LOAD  = 2'd3;

	// register indexes
	localparam logic [1:0] REG_STOP = 2'd0;
	localparam logic [1:0] REG_TVG  = 2'd1;
	localparam logic [1:0] REG_RVG  = 2'd2;
	localparam logic [1:0] REG_HYST = 2'd3;

	// register reset values
	localparam logic [14:0] STOP_RST = 15'd4289;
	localparam logic [15:0] TVG_RST  = 16'd256;
	localparam logic [15:0] RVG_RST  = 16'd256;
	localparam logic [15:0] HYST_RST = 16'd512;

	// atan(2^-i) in Q3.13, rounded
	function automatic logic [12:0] atan_tab(input logic [4:0] i);
		logic [12:0] v;
		case (i)
			5'd0:    v = 13'd6434;
			5'd1:    v = 13'd3798;
			5'd2:    v = 13'd2007;
			5'd3:    v = 13'd1019;
			5'd4:    v = 13'd511;
			5'd5:    v = 13'd256;
			5'd6:    v = 13'd128;
			5'd7:    v = 13'd64;
			5'd8:    v = 13'd32;
			5'd9:    v = 13'd16;
			5'd10:   v = 13'd8;
			5'd11:   v = 13'd4;
			5'd12:   v = 13'd2;
			5'd13:   v = 13'd1;
			default: v = 13'd0;
		endcase
		return v;
	endfunction

endpackage

FILE: src/wdc_mul.sv
// ----------------------------------------------------------------------------
// wdc_mul: shared signed multiplier
// one signed product per cycle, registered at the output
// ----------------------------------------------------------------------------
module wdc_mul (
	input  logic                                clk,
	input  logic signed [wdc_pkg::MUL_W-1:0]    a,
	input  logic signed [wdc_pkg::MUL_W-1:0]    b,
	output logic signed [wdc_pkg::PROD_W-1:0]   p
);
	import wdc_pkg::*;

	logic signed [PROD_W-1:0] p_q;

	always_ff @(posedge clk) begin
		p_q <= PROD_W'(a) * PROD_W'(b);
	end

	assign p = p_q;

endmodule

FILE: src/wdc_sqrt.sv
// ----------------------------------------------------------------------------
// wdc_sqrt: iterative integer square root
// restoring method, one result bit per cycle, floor of the root
// ----------------------------------------------------------------------------
module wdc_sqrt (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic [wdc_pkg::RAD_W-1:0]    rad,
	output logic                         done,
	output logic [wdc_pkg::ROOT_W-1:0]   root
);
	import wdc_pkg::*;

	localparam int SH_W  = 2 * ROOT_W;
	localparam int REM_W = ROOT_W + 4;
	localparam int CNT_W = $clog2(ROOT_W);

	logic [SH_W-1:0]   rad_q;
	logic [REM_W-1:0]  rem_q;
	logic [ROOT_W-1:0] root_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              busy_q;
	logic              done_q;
	logic [REM_W-1:0]  rem_sh;
	logic [REM_W-1:0]  trial;

	always_comb begin
		rem_sh = {rem_q[REM_W-3:0], rad_q[SH_W-1 -: 2]};
		trial  = REM_W'({root_q, 2'b01});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(ROOT_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rad_q  <= SH_W'(rad);
			rem_q  <= '0;
			root_q <= '0;
		end else if (busy_q) begin
			rad_q <= rad_q << 2;
			if (rem_sh >= trial) begin
				rem_q  <= rem_sh - trial;
				root_q <= {root_q[ROOT_W-2:0], 1'b1};
			end else begin
				rem_q  <= rem_sh;
				root_q <= {root_q[ROOT_W-2:0], 1'b0};
			end
		end
	end

	assign done = done_q;
	assign root = root_q;

endmodule

FILE: src/wdc_cordic.sv
// ----------------------------------------------------------------------------
// wdc_cordic: iterative cordic atan2
// scales the vector up, folds the left half plane, then one rotation per cycle
// ----------------------------------------------------------------------------
module wdc_cordic #(
	parameter int STEPS = wdc_pkg::CORDIC_STEPS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	input  logic signed [wdc_pkg::XY_W-1:0]   xa,
	input  logic signed [wdc_pkg::XY_W-1:0]   ya,
	output logic                              done,
	output logic signed [wdc_pkg::ANG_W-1:0]  angle
);
	import wdc_pkg::*;

	localparam int IT_W = (STEPS > 1) ? $clog2(STEPS) : 1;
	localparam logic signed [CRD_W-1:0] LIM  = CRD_W'(64'sd4503599627370496);
	localparam logic signed [CRD_W-1:0] NLIM = -LIM;

	localparam logic [1:0] C_IDLE = 2'd0;
	localparam logic [1:0] C_NORM = 2'd1;
	localparam logic [1:0] C_ITER = 2'd2;

	logic [1:0]              ph_q;
	logic [IT_W-1:0]         it_q;
	logic                    done_q;
	logic signed [CRD_W-1:0] x_q;
	logic signed [CRD_W-1:0] y_q;
	logic signed [ANG_W-1:0] z_q;
	logic signed [CRD_W-1:0] xs;
	logic signed [CRD_W-1:0] ys;
	logic signed [ANG_W-1:0] at;
	logic                    small_vec;

	always_comb begin
		xs        = x_q >>> it_q;
		ys        = y_q >>> it_q;
		at        = $signed({4'b0, atan_tab(5'(it_q))});
		small_vec = (x_q < LIM) && (x_q > NLIM) && (y_q < LIM) && (y_q > NLIM);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph_q   <= C_IDLE;
			it_q   <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (ph_q)
				C_IDLE: begin
					if (start) ph_q <= C_NORM;
				end
				C_NORM: begin
					if (!small_vec) begin
						ph_q <= C_ITER;
						it_q <= '0;
					end
				end
				C_ITER: begin
					it_q <= it_q + 1'b1;
					if (it_q == IT_W'(STEPS - 1)) begin
						ph_q   <= C_IDLE;
						done_q <= 1'b1;
					end
				end
				default: ph_q <= C_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (ph_q)
			C_IDLE: begin
				if (start) begin
					x_q <= CRD_W'(xa);
					y_q <= CRD_W'(ya);
					z_q <= '0;
				end
			end
			C_NORM: begin
				if (small_vec) begin
					x_q <= x_q <<< 1;
					y_q <= y_q <<< 1;
				end else if (x_q < 0) begin
					// fold the left half plane by a quarter turn
					if (y_q >= 0) begin
						x_q <= y_q;
						y_q <= -x_q;
						z_q <= ANG_W'(HALF_PI);
					end else begin
						x_q <= -y_q;
						y_q <= x_q;
						z_q <= -ANG_W'(HALF_PI);
					end
				end
			end
			C_ITER: begin
				if (!y_q[CRD_W-1]) begin
					x_q <= x_q + ys;
					y_q <= y_q - xs;
					z_q <= z_q + at;
				end else begin
					x_q <= x_q - ys;
					y_q <= y_q + xs;
					z_q <= z_q - at;
				end
			end
			default: ;
		endcase
	end

	assign done  = done_q;
	assign angle = z_q;

endmodule

FILE: src/waypoint_drive_command_unit.sv
// ----------------------------------------------------------------------------
// waypoint_drive_command_unit: proportional drive command toward one target
// a target transfer stores the goal pose, a pose transfer returns speed commands
// ----------------------------------------------------------------------------
// sequence: a target load or an early status goes straight to the output register;
// a full command runs the squared deltas, four square root passes, the window tests,
// the quaternion and heading products on the shared multiplier, the cordic with its
// scaling and rotations, then the rotational speed
// throughput: one item at a time; the next transfer is taken once the result is out
// reset: asynchronous, clears target, aligning flag and registers to defaults
// ----------------------------------------------------------------------------
module waypoint_drive_command_unit #(
	parameter int CORDIC_STEPS = wdc_pkg::CORDIC_STEPS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	// input item
	input  logic               in_valid,
	output logic               in_ready,
	input  logic               mode,
	input  logic signed [31:0] pos_x,
	input  logic signed [31:0] pos_y,
	input  logic signed [31:0] pos_z,
	input  logic signed [15:0] quat_w,
	input  logic signed [15:0] quat_x,
	input  logic signed [15:0] quat_y,
	input  logic signed [15:0] quat_z,
	input  logic [31:0]        var_x,
	input  logic [31:0]        var_y,
	input  logic [31:0]        var_z,
	// result item
	output logic               out_valid,
	input  logic               out_ready,
	output logic [30:0]        tv_cmd,
	output logic signed [31:0] rv_cmd,
	output logic [1:0]         status,
	output logic               aligning_flag,
	// register port
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [3:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready
);
	import wdc_pkg::*;

	// sequencer states
	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_SQ   = 4'd1;   // squared deltas
	localparam logic [3:0] S_SQD  = 4'd2;   // root of distance
	localparam logic [3:0] S_SQR  = 4'd3;   // root of one axis variance
	localparam logic [3:0] S_HYS  = 4'd4;   // inner window test of one axis
	localparam logic [3:0] S_TV   = 4'd5;   // translational speed
	localparam logic [3:0] S_QA   = 4'd6;   // quaternion products
	localparam logic [3:0] S_MAT  = 4'd7;   // matrix rows or relative quaternion
	localparam logic [3:0] S_QB   = 4'd8;   // heading vector products
	localparam logic [3:0] S_XY   = 4'd9;   // heading vector finish
	localparam logic [3:0] S_ATAN = 4'd10;  // cordic
	localparam logic [3:0] S_RV   = 4'd11;  // rotational speed
	localparam logic [3:0] S_OUT  = 4'd12;  // hand result to output register

	localparam logic signed [35:0] ONE28_36 = 36'sd268435456;
	localparam logic signed [XY_W-1:0] ONE28_XY = XY_W'(64'sd268435456);

	// registers
	logic [14:0] sta_q;
	logic [15:0] tvg_q;
	logic [15:0] rvg_q;
	logic [15:0] hr_q;

	// target store
	logic signed [31:0] tp_q [3];
	logic signed [15:0] tq_q [4];
	logic [31:0]        tvar_q [3];
	logic               tvalid_q;
	logic               align_q;

	// per-item working state
	logic [3:0]         state_q;
	logic [4:0]         k_q;
	logic [1:0]         ax_q;
	logic signed [15:0] cq_q [4];
	logic signed [32:0] d_q [3];
	logic [32:0]        a_q [3];
	logic [RAD_W-1:0]   acc_q;
	logic [ROOT_W-1:0]  dist_q;
	logic [23:0]        r_q;
	logic               inner_q;
	logic               outer_q;
	logic [30:0]        tvs_q;
	logic signed [31:0] pr_q [16];
	logic signed [19:0] m_q [6];
	logic signed [XY_W-1:0] xv_q;
	logic signed [XY_W-1:0] yv_q;
	logic signed [ANG_W-1:0] ang_q;

	// result and output registers
	logic [30:0]        res_tv_q;
	logic signed [31:0] res_rv_q;
	logic [1:0]         res_st_q;
	logic               ov_q;
	logic [30:0]        otv_q;
	logic signed [31:0] orv_q;
	logic [1:0]         ost_q;
	logic               oal_q;

	// combinational
	logic                     in_fire;
	logic                     cfg_wr;
	logic                     var_bad;
	logic signed [31:0]       pos_in [3];
	logic signed [32:0]       dn [3];
	logic [32:0]              an [3];
	logic [1:0]               idx;
	logic signed [MUL_W-1:0]  mul_a;
	logic signed [MUL_W-1:0]  mul_b;
	logic signed [PROD_W-1:0] prod;
	logic                     sq_start;
	logic [RAD_W-1:0]         sq_rad;
	logic                     sq_done;
	logic [ROOT_W-1:0]        sq_root;
	logic                     cor_start;
	logic                     cor_done;
	logic signed [ANG_W-1:0]  cor_ang;
	logic                     xy_zero;
	logic [4:0]               qa_n;
	logic [4:0]               qb_n;
	logic [3:0]               pr_wi;
	logic [2:0]               qb_op;
	logic signed [35:0]       pe [16];
	logic signed [35:0]       mt [6];
	logic signed [PROD_W-1:0] rv_sh;
	logic [ANG_W-1:0]         ang_abs;
	logic                     new_align;
	logic                     out_load;

	assign in_ready = (state_q == S_IDLE);
	assign in_fire  = in_valid && in_ready;
	assign cfg_wr   = psel && penable && pwrite;
	assign pready   = 1'b1;
	assign out_load = (state_q == S_OUT) && (!ov_q || out_ready);

	// register file
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sta_q <= STOP_RST;
			tvg_q <= TVG_RST;
			rvg_q <= RVG_RST;
			hr_q  <= HYST_RST;
		end else if (cfg_wr) begin
			case (paddr[3:2])
				REG_STOP: sta_q <= pwdata[14:0];
				REG_TVG:  tvg_q <= pwdata[15:0];
				REG_RVG:  rvg_q <= pwdata[15:0];
				REG_HYST: hr_q  <= pwdata[15:0];
				default:  ;
			endcase
		end
	end

	always_comb begin
		case (paddr[3:2])
			REG_STOP: prdata = {17'b0, sta_q};
			REG_TVG:  prdata = {16'b0, tvg_q};
			REG_RVG:  prdata = {16'b0, rvg_q};
			REG_HYST: prdata = {16'b0, hr_q};
			default:  prdata = '0;
		endcase
	end

	// deltas to the target and the variance gate, formed at the input transfer
	always_comb begin
		pos_in[0] = pos_x;
		pos_in[1] = pos_y;
		pos_in[2] = pos_z;
		for (int i = 0; i < 3; i++) begin
			dn[i] = {tp_q[i][31], tp_q[i]} - {pos_in[i][31], pos_in[i]};
			an[i] = dn[i][32] ? 33'(-dn[i]) : 33'(dn[i]);
		end
		var_bad = (var_x > tvar_q[0]) || (var_y > tvar_q[1]) || (var_z > tvar_q[2]);
	end

	// operand selection for the shared multiplier
	always_comb begin
		idx   = (state_q == S_SQ) ? k_q[1:0] : ax_q;
		qa_n  = align_q ? 5'd16 : 5'd9;
		qb_n  = align_q ? 5'd4 : 5'd6;
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			S_SQ: begin
				mul_a = MUL_W'(a_q[idx]);
				mul_b = MUL_W'(a_q[idx]);
			end
			S_HYS: begin
				mul_a = MUL_W'(a_q[idx]);
				mul_b = MUL_W'(hr_q);
			end
			S_TV: begin
				mul_a = MUL_W'(dist_q);
				mul_b = MUL_W'(tvg_q);
			end
			S_QA: begin
				if (align_q) begin
					// current conjugate times target, all sixteen cross terms
					mul_a = MUL_W'(cq_q[k_q[3:2]]);
					mul_b = MUL_W'(tq_q[k_q[1:0]]);
				end else begin
					case (k_q)
						5'd0: begin mul_a = MUL_W'(cq_q[2]); mul_b = MUL_W'(cq_q[2]); end
						5'd1: begin mul_a = MUL_W'(cq_q[3]); mul_b = MUL_W'(cq_q[3]); end
						5'd2: begin mul_a = MUL_W'(cq_q[1]); mul_b = MUL_W'(cq_q[2]); end
						5'd3: begin mul_a = MUL_W'(cq_q[0]); mul_b = MUL_W'(cq_q[3]); end
						5'd4: begin mul_a = MUL_W'(cq_q[1]); mul_b = MUL_W'(cq_q[3]); end
						5'd5: begin mul_a = MUL_W'(cq_q[0]); mul_b = MUL_W'(cq_q[2]); end
						5'd6: begin mul_a = MUL_W'(cq_q[1]); mul_b = MUL_W'(cq_q[1]); end
						5'd7: begin mul_a = MUL_W'(cq_q[2]); mul_b = MUL_W'(cq_q[3]); end
						5'd8: begin mul_a = MUL_W'(cq_q[0]); mul_b = MUL_W'(cq_q[1]); end
						default: ;
					endcase
				end
			end
			S_QB: begin
				if (align_q) begin
					case (k_q)
						5'd0: begin mul_a = MUL_W'(m_q[1]); mul_b = MUL_W'(m_q[2]); end
						5'd1: begin mul_a = MUL_W'(m_q[0]); mul_b = MUL_W'(m_q[3]); end
						5'd2: begin mul_a = MUL_W'(m_q[1]); mul_b = MUL_W'(m_q[1]); end
						5'd3: begin mul_a = MUL_W'(m_q[3]); mul_b = MUL_W'(m_q[3]); end
						default: ;
					endcase
				end else begin
					case (k_q)
						5'd0: begin mul_a = MUL_W'(m_q[0]); mul_b = MUL_W'(d_q[0]); end
						5'd1: begin mul_a = MUL_W'(m_q[1]); mul_b = MUL_W'(d_q[1]); end
						5'd2: begin mul_a = MUL_W'(m_q[2]); mul_b = MUL_W'(d_q[2]); end
						5'd3: begin mul_a = MUL_W'(m_q[3]); mul_b = MUL_W'(d_q[0]); end
						5'd4: begin mul_a = MUL_W'(m_q[4]); mul_b = MUL_W'(d_q[1]); end
						5'd5: begin mul_a = MUL_W'(m_q[5]); mul_b = MUL_W'(d_q[2]); end
						default: ;
					endcase
				end
			end
			S_RV: begin
				mul_a = MUL_W'(rvg_q);
				mul_b = MUL_W'(ang_q);
			end
			default: ;
		endcase
	end

	wdc_mul u_mul (
		.clk (clk),
		.a   (mul_a),
		.b   (mul_b),
		.p   (prod)
	);

	// square root shared by distance and the three window radii
	assign sq_start = ((state_q == S_SQD) || (state_q == S_SQR)) && (k_q == 5'd0);
	assign sq_rad   = (state_q == S_SQD) ? acc_q : {18'b0, tvar_q[ax_q], 16'h0};

	wdc_sqrt u_sqrt (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (sq_start),
		.rad    (sq_rad),
		.done   (sq_done),
		.root   (sq_root)
	);

	assign xy_zero   = (xv_q == '0) && (yv_q == '0);
	assign cor_start = (state_q == S_ATAN) && (k_q == 5'd0) && !xy_zero;

	wdc_cordic #(
		.STEPS (CORDIC_STEPS)
	) u_cordic (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cor_start),
		.xa     (yv_q),
		.ya     (-xv_q),
		.done   (cor_done),
		.angle  (cor_ang)
	);

	// matrix rows of the conjugate, or the relative quaternion when aligning
	always_comb begin
		for (int i = 0; i < 16; i++) begin
			pe[i] = 36'(pr_q[i]);
		end
		if (align_q) begin
			mt[0] = pe[0] + pe[5] + pe[10] + pe[15];
			mt[1] = pe[1] - pe[4] - pe[11] + pe[14];
			mt[2] = pe[2] + pe[7] - pe[8] - pe[13];
			mt[3] = pe[3] - pe[6] + pe[9] - pe[12];
			mt[4] = '0;
			mt[5] = '0;
		end else begin
			mt[0] = ONE28_36 - ((pe[0] + pe[1]) <<< 1);
			mt[1] = (pe[2] + pe[3]) <<< 1;
			mt[2] = (pe[4] - pe[5]) <<< 1;
			mt[3] = (pe[2] - pe[3]) <<< 1;
			mt[4] = ONE28_36 - ((pe[6] + pe[1]) <<< 1);
			mt[5] = (pe[7] + pe[8]) <<< 1;
		end
	end

	always_comb begin
		pr_wi     = 4'(k_q - 5'd1);
		qb_op     = 3'(k_q - 5'd1);
		rv_sh     = prod >>> 5;
		ang_abs   = ang_q[ANG_W-1] ? ANG_W'(-ang_q) : ANG_W'(ang_q);
		new_align = (align_q || inner_q) && outer_q;
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			k_q      <= '0;
			ax_q     <= '0;
			tvalid_q <= 1'b0;
			align_q  <= 1'b0;
			ov_q     <= 1'b0;
			for (int i = 0; i < 3; i++) begin
				tp_q[i]   <= '0;
				tvar_q[i] <= '0;
			end
			for (int i = 0; i < 4; i++) begin
				tq_q[i] <= '0;
			end
		end else begin
			if (out_load) begin
				ov_q <= 1'b1;
			end else if (out_ready) begin
				ov_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_fire) begin
						state_q <= S_OUT;
						if (!mode) begin
							tp_q[0]   <= pos_x;
							tp_q[1]   <= pos_y;
							tp_q[2]   <= pos_z;
							tq_q[0]   <= quat_w;
							tq_q[1]   <= quat_x;
							tq_q[2]   <= quat_y;
							tq_q[3]   <= quat_z;
							tvar_q[0] <= var_x;
							tvar_q[1] <= var_y;
							tvar_q[2] <= var_z;
							tvalid_q  <= 1'b1;
							align_q   <= 1'b0;
						end else if (!var_bad && tvalid_q) begin
							state_q <= S_SQ;
							k_q     <= '0;
						end
					end
				end
				S_SQ: begin
					if (k_q == 5'd3) begin
						state_q <= S_SQD;
						k_q     <= '0;
					end else begin
						k_q <= k_q + 5'd1;
					end
				end
				S_SQD: begin
					if (k_q == 5'd0) begin
						k_q <= 5'd1;
					end else if (sq_done) begin
						state_q <= S_SQR;
						k_q     <= '0;
						ax_q    <= '0;
					end
				end
				S_SQR: begin
					if (k_q == 5'd0) begin
						k_q <= 5'd1;
					end else if (sq_done) begin
						state_q <= S_HYS;
						k_q     <= '0;
					end
				end
				S_HYS: begin
					if (k_q == 5'd0) begin
						k_q <= 5'd1;
					end else begin
						k_q <= '0;
						if (ax_q == 2'd2) begin
							state_q <= S_TV;
						end else begin
							ax_q    <= ax_q + 2'd1;
							state_q <= S_SQR;
						end
					end
				end
				S_TV: begin
					if (k_q == 5'd0) begin
						k_q <= 5'd1;
					end else begin
						// inner window sets aligning, leaving the outer window clears it
						align_q <= new_align;
						state_q <= S_QA;
						k_q     <= '0;
					end
				end
				S_QA: begin
					if (k_q == qa_n) begin
						state_q <= S_MAT;
						k_q     <= '0;
					end else begin
						k_q <= k_q + 5'd1;
					end
				end
				S_MAT: begin
					state_q <= S_QB;
					k_q     <= '0;
				end
				S_QB: begin
					if (k_q == qb_n) begin
						state_q <= S_XY;
						k_q     <= '0;
					end else begin
						k_q <= k_q + 5'd1;
					end
				end
				S_XY: begin
					state_q <= S_ATAN;
					k_q     <= '0;
				end
				S_ATAN: begin
					if (k_q == 5'd0) begin
						if (xy_zero) begin
							state_q <= S_RV;
						end else begin
							k_q <= 5'd1;
						end
					end else if (cor_done) begin
						state_q <= S_RV;
						k_q     <= '0;
					end
				end
				S_RV: begin
					if (k_q == 5'd0) begin
						k_q <= 5'd1;
					end else begin
						state_q <= S_OUT;
						k_q     <= '0;
					end
				end
				S_OUT: begin
					if (out_load) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (in_fire) begin
					cq_q[0]  <= quat_w;
					cq_q[1]  <= quat_x;
					cq_q[2]  <= quat_y;
					cq_q[3]  <= quat_z;
					for (int i = 0; i < 3; i++) begin
						d_q[i] <= dn[i];
						a_q[i] <= an[i];
					end
					acc_q    <= '0;
					inner_q  <= 1'b1;
					outer_q  <= 1'b1;
					res_tv_q <= '0;
					res_rv_q <= '0;
					if (!mode) begin
						res_st_q <= ST_LOAD;
					end else if (var_bad) begin
						res_st_q <= ST_VAR;
					end else if (!tvalid_q) begin
						res_st_q <= ST_NOTGT;
					end else begin
						res_st_q <= ST_DRIVE;
					end
				end
			end
			S_SQ: begin
				if (k_q != 5'd0) acc_q <= acc_q + prod[RAD_W-1:0];
			end
			S_SQD: begin
				if (k_q != 5'd0 && sq_done) dist_q <= sq_root;
			end
			S_SQR: begin
				if (k_q != 5'd0 && sq_done) begin
					r_q <= sq_root[23:0];
					if ({1'b0, a_q[ax_q]} > sq_root) outer_q <= 1'b0;
				end
			end
			S_HYS: begin
				if (k_q != 5'd0) begin
					if ((prod[PROD_W-1:32] != '0) || (prod[31:0] > {r_q, 8'h00})) begin
						inner_q <= 1'b0;
					end
				end
			end
			S_TV: begin
				if (k_q != 5'd0) begin
					tvs_q <= (prod[PROD_W-1:39] != '0) ? 31'h7fff_ffff : prod[38:8];
				end
			end
			S_QA: begin
				if (k_q != 5'd0) pr_q[pr_wi] <= prod[31:0];
			end
			S_MAT: begin
				for (int i = 0; i < 6; i++) begin
					m_q[i] <= 20'(mt[i] >>> 14);
				end
				xv_q <= '0;
				yv_q <= '0;
			end
			S_QB: begin
				if (k_q != 5'd0) begin
					if (align_q) begin
						case (qb_op)
							3'd0:    xv_q <= xv_q + prod[XY_W-1:0];
							3'd1:    xv_q <= xv_q - prod[XY_W-1:0];
							default: yv_q <= yv_q + prod[XY_W-1:0];
						endcase
					end else if (qb_op < 3'd3) begin
						xv_q <= xv_q + prod[XY_W-1:0];
					end else begin
						yv_q <= yv_q + prod[XY_W-1:0];
					end
				end
			end
			S_XY: begin
				if (align_q) begin
					xv_q <= xv_q <<< 1;
					yv_q <= ONE28_XY - (yv_q <<< 1);
				end
			end
			S_ATAN: begin
				if (k_q == 5'd0) begin
					if (xy_zero) ang_q <= '0;
				end else if (cor_done) begin
					ang_q <= cor_ang;
				end
			end
			S_RV: begin
				if (k_q != 5'd0) begin
					if (rv_sh > PROD_W'(64'sd2147483647)) begin
						res_rv_q <= 32'sh7fff_ffff;
					end else if (rv_sh < PROD_W'(-64'sd2147483648)) begin
						res_rv_q <= 32'sh8000_0000;
					end else begin
						res_rv_q <= rv_sh[31:0];
					end
					// large heading error or turning in place stops translation
					if ((ang_abs > ANG_W'(sta_q)) || align_q) begin
						res_tv_q <= '0;
					end else begin
						res_tv_q <= tvs_q;
					end
				end
			end
			default: ;
		endcase
		if (out_load) begin
			otv_q <= res_tv_q;
			orv_q <= res_rv_q;
			ost_q <= res_st_q;
			oal_q <= align_q;
		end
	end

	assign out_valid     = ov_q;
	assign tv_cmd        = otv_q;
	assign rv_cmd        = orv_q;
	assign status        = ost_q;
	assign aligning_flag = oal_q;

	// the sequencer is busy in the cycle after any input transfer
	a_busy_after_take: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input taken while an item is in progress");

	a_load_result: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == ST_LOAD |-> tv_cmd == '0 && rv_cmd == '0 && !aligning_flag)
		else $error("target load result not cleared");

	a_no_drive_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != ST_DRIVE |-> tv_cmd == '0 && rv_cmd == '0)
		else $error("speed given without a drive status");

	a_align_no_tv: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == ST_DRIVE && aligning_flag |-> tv_cmd == '0)
		else $error("translation while aligning");

endmodule

FILE: verif/waypoint_drive_command_unit_tb.sv
// ----------------------------------------------------------------------------
// waypoint_drive_command_unit_tb: self-checking bench of the drive command unit
// a scoreboard predicts every command from the target and pose transfers, and
// directed and random poses run under several register settings, with random
// stalls on both handshakes
// ----------------------------------------------------------------------------
import wdc_pkg::*;

typedef struct {
	bit               mode;
	bit signed [31:0] pos[3];
	bit signed [15:0] q[4];
	bit [31:0]        variance[3];
} pose_t;

typedef struct {
	bit [30:0] tv;
	bit [31:0] rv;
	bit [1:0]  st;
	bit        al;
} drive_cmd_t;

// mirror of the block state and the expected commands
class drive_scoreboard;
	longint     tgt_pos[3];
	longint     tgt_q[4];
	bit [31:0]  tgt_var[3];
	bit         tgt_valid;
	bit         aligning;
	bit [14:0]  stop_angle = STOP_RST;
	bit [15:0]  tv_gain = TVG_RST;
	bit [15:0]  rv_gain = RVG_RST;
	bit [15:0]  hyst = HYST_RST;
	drive_cmd_t cmd_q[$];
	int         errors;

	function bit [33:0] floor_sqrt(bit [127:0] v);
		bit [33:0]  r;
		bit [127:0] c;
		r = 0;
		for (int b = 33; b >= 0; b--) begin
			c = r | (34'd1 << b);
			if (c * c <= v) r = c[33:0];
		end
		return r;
	endfunction

	function int heading(longint ya, longint xa);
		int     atab[14] = '{6434, 3798, 2007, 1019, 511, 256, 128, 64, 32, 16, 8, 4, 2, 1};
		longint x, y, t, xs, ys, lim;
		int     z;
		x = xa;
		y = ya;
		z = 0;
		lim = 64'sd1 <<< 52;
		while (x < lim && x > -lim && y < lim && y > -lim) begin
			x = x * 2;
			y = y * 2;
		end
		if (x < 0) begin
			t = x;
			if (y >= 0) begin
				x = y; y = -t; z = HALF_PI;
			end else begin
				x = -y; y = t; z = -HALF_PI;
			end
		end
		for (int i = 0; i < CORDIC_STEPS_DEF; i++) begin
			xs = x >>> i;
			ys = y >>> i;
			if (y >= 0) begin
				x = x + ys; y = y - xs; z += (i < 14) ? atab[i] : 0;
			end else begin
				x = x - ys; y = y + xs; z -= (i < 14) ? atab[i] : 0;
			end
		end
		return z;
	endfunction

	function void write_reg(bit [1:0] idx, bit [31:0] v);
		case (idx)
			REG_STOP: stop_angle = v[14:0];
			REG_TVG:  tv_gain = v[15:0];
			REG_RVG:  rv_gain = v[15:0];
			REG_HYST: hyst = v[15:0];
		endcase
	endfunction

	// predict the command caused by one accepted transfer
	function void note_pose(pose_t p);
		drive_cmd_t e;
		longint     d[3], a, rad, X, Y, w, x, y, z, one, tvv, rv;
		longint     r00, r01, r02, r10, r11, r12, aw, ax, ay, az, pw, px, py, pz;
		bit [127:0] sum;
		bit         inner, outer;
		int         angle;
		e = '{0, 0, ST_DRIVE, 0};
		if (!p.mode) begin
			foreach (tgt_pos[i]) begin
				tgt_pos[i] = p.pos[i];
				tgt_var[i] = p.variance[i];
			end
			foreach (tgt_q[i]) tgt_q[i] = p.q[i];
			tgt_valid = 1;
			aligning = 0;
			e.st = ST_LOAD;
			cmd_q.push_back(e);
			return;
		end
		if (p.variance[0] > tgt_var[0] || p.variance[1] > tgt_var[1] ||
				p.variance[2] > tgt_var[2]) begin
			e.st = ST_VAR;
			e.al = aligning;
			cmd_q.push_back(e);
			return;
		end
		if (!tgt_valid) begin
			e.st = ST_NOTGT;
			e.al = aligning;
			cmd_q.push_back(e);
			return;
		end
		sum = 0;
		inner = 1;
		outer = 1;
		for (int i = 0; i < 3; i++) begin
			d[i] = tgt_pos[i] - longint'(p.pos[i]);
			a = (d[i] < 0) ? -d[i] : d[i];
			sum += 128'(a) * 128'(a);
			rad = longint'(floor_sqrt({80'd0, tgt_var[i], 16'd0}));
			if (a * longint'(hyst) > rad * 256) inner = 0;
			if (a > rad) outer = 0;
		end
		tvv = longint'(floor_sqrt(sum)) * longint'(tv_gain) >>> 8;
		if (tvv > 64'sd2147483647) tvv = 64'sd2147483647;
		if (inner) aligning = 1;
		if (!outer) aligning = 0;
		one = 64'sd1 <<< 28;
		if (!aligning) begin
			w = p.q[0]; x = p.q[1]; y = p.q[2]; z = p.q[3];
			r00 = (one - 2 * (y * y + z * z)) >>> 14;
			r01 = (2 * (x * y + w * z)) >>> 14;
			r02 = (2 * (x * z - w * y)) >>> 14;
			r10 = (2 * (x * y - w * z)) >>> 14;
			r11 = (one - 2 * (x * x + z * z)) >>> 14;
			r12 = (2 * (y * z + w * x)) >>> 14;
			X = r00 * d[0] + r01 * d[1] + r02 * d[2];
			Y = r10 * d[0] + r11 * d[1] + r12 * d[2];
		end else begin
			// relative rotation from the conjugate of the current pose
			aw = p.q[0]; ax = -longint'(p.q[1]); ay = -longint'(p.q[2]); az = -longint'(p.q[3]);
			pw = (aw * tgt_q[0] - ax * tgt_q[1] - ay * tgt_q[2] - az * tgt_q[3]) >>> 14;
			px = (aw * tgt_q[1] + ax * tgt_q[0] + ay * tgt_q[3] - az * tgt_q[2]) >>> 14;
			py = (aw * tgt_q[2] - ax * tgt_q[3] + ay * tgt_q[0] + az * tgt_q[1]) >>> 14;
			pz = (aw * tgt_q[3] + ax * tgt_q[2] - ay * tgt_q[1] + az * tgt_q[0]) >>> 14;
			X = 2 * (px * py - pw * pz);
			Y = one - 2 * (px * px + pz * pz);
		end
		angle = (X != 0 || Y != 0) ? heading(-X, Y) : 0;
		if (((angle < 0) ? -angle : angle) > int'(stop_angle) || aligning) tvv = 0;
		rv = (longint'(rv_gain) * longint'(angle)) >>> 5;
		if (rv > 64'sd2147483647) rv = 64'sd2147483647;
		if (rv < -64'sd2147483648) rv = -64'sd2147483648;
		e.tv = tvv[30:0];
		e.rv = rv[31:0];
		e.al = aligning;
		cmd_q.push_back(e);
	endfunction

	function void check_cmd(drive_cmd_t got);
		drive_cmd_t e;
		if (cmd_q.size() == 0) begin
			$error("command transfer with nothing expected");
			errors++;
			return;
		end
		e = cmd_q.pop_front();
		if (got.tv !== e.tv) begin
			$error("tv_cmd expected %0d actual %0d", e.tv, got.tv); errors++;
		end
		if (got.rv !== e.rv) begin
			$error("rv_cmd expected %0d actual %0d", $signed(e.rv), $signed(got.rv)); errors++;
		end
		if (got.st !== e.st) begin
			$error("status expected %0d actual %0d", e.st, got.st); errors++;
		end
		if (got.al !== e.al) begin
			$error("aligning_flag expected %0d actual %0d", e.al, got.al); errors++;
		end
	endfunction
endclass

module waypoint_drive_command_unit_tb;

	localparam int CYCLE_LIMIT = 1000000;
	localparam int SETTLE = 300;  // longer than the slowest command

	logic               clk = 0;
	logic               arst_n = 0;
	logic               in_valid = 0;
	logic               in_ready;
	logic               mode = 0;
	logic signed [31:0] pos_x = 0, pos_y = 0, pos_z = 0;
	logic signed [15:0] quat_w = 0, quat_x = 0, quat_y = 0, quat_z = 0;
	logic [31:0]        var_x = 0, var_y = 0, var_z = 0;
	logic               out_valid;
	logic               out_ready = 0;
	logic [30:0]        tv_cmd;
	logic signed [31:0] rv_cmd;
	logic [1:0]         status;
	logic               aligning_flag;
	logic               psel = 0, penable = 0, pwrite = 0;
	logic [3:0]         paddr = 0;
	logic [31:0]        pwdata = 0;
	logic [31:0]        prdata;
	logic               pready;

	drive_scoreboard sb = new();
	bit              calm;       // no idling on either side while set
	int              cycles;
	pose_t           last_tgt;   // stimulus side copy of the loaded target

	waypoint_drive_command_unit dut (.*);

	always begin
		#5 clk = 1;
		#5 clk = 0;
	end

	// run guard
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	// receiver stalls at random, 15 times in a hundred, except while calm is set
	always @(posedge clk)
		out_ready <= calm || ($urandom_range(0, 99) >= 15);

	// every command transfer goes to the scoreboard
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			sb.check_cmd('{tv_cmd, rv_cmd, status, aligning_flag});
	end

	function automatic pose_t mk(bit m, int px, int py, int pz, int qw, int qx, int qy,
			int qz, bit [31:0] vx, bit [31:0] vy, bit [31:0] vz);
		pose_t p;
		p.mode = m;
		p.pos = '{px, py, pz};
		p.q = '{qw[15:0], qx[15:0], qy[15:0], qz[15:0]};
		p.variance = '{vx, vy, vz};
		return p;
	endfunction

	// setup and access cycle of one register write
	task automatic reg_write(bit [1:0] idx, bit [31:0] v);
		psel <= 1; penable <= 0; pwrite <= 1; paddr <= {idx, 2'b00}; pwdata <= v;
		@(posedge clk);
		penable <= 1;
		@(posedge clk);
		psel <= 0; penable <= 0; pwrite <= 0;
		sb.write_reg(idx, v);
		@(posedge clk);
	endtask

	// one input transfer, with an optional random gap ahead of it
	task automatic send(pose_t p);
		if (!calm && $urandom_range(0, 99) < 15) begin
			in_valid <= 0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
		in_valid <= 1;
		mode <= p.mode;
		pos_x <= p.pos[0]; pos_y <= p.pos[1]; pos_z <= p.pos[2];
		quat_w <= p.q[0]; quat_x <= p.q[1]; quat_y <= p.q[2]; quat_z <= p.q[3];
		var_x <= p.variance[0]; var_y <= p.variance[1]; var_z <= p.variance[2];
		do @(posedge clk); while (!in_ready);
		sb.note_pose(p);
		if (!p.mode) last_tgt = p;
	endtask

	task automatic wait_drained();
		while (sb.cmd_q.size() != 0) @(posedge clk);
	endtask

	function automatic bit signed [15:0] rand_q();
		if ($urandom_range(0, 9) == 0) return 16'($urandom());
		return 16'($signed($urandom_range(0, 32768)) - 16384);
	endfunction

	// random transfer, mostly poses that pass the variance gate near the target
	function automatic pose_t rand_item();
		pose_t p;
		int    k;
		p.mode = ($urandom_range(0, 99) >= 15);
		foreach (p.q[i]) p.q[i] = rand_q();
		if (!p.mode) begin
			foreach (p.pos[i]) p.pos[i] = ($urandom_range(0, 3) == 0) ? $urandom()
				: $signed($urandom_range(0, 1 << 22)) - (1 << 21);
			foreach (p.variance[i]) p.variance[i] = ($urandom_range(0, 4) == 0) ?
				$urandom_range(0, 1 << 16) : $urandom();
			return p;
		end
		k = $urandom_range(0, 31);
		foreach (p.pos[i])
			p.pos[i] = (k == 0) ? last_tgt.pos[i] :
				last_tgt.pos[i] + $signed($urandom() & ((32'd1 << k) - 1)) - (1 << (k - 1));
		foreach (p.variance[i])
			p.variance[i] = ($urandom_range(0, 9) == 0) ? $urandom() :
				$urandom_range(0, last_tgt.variance[i]);
		return p;
	endfunction

	initial begin
		pose_t p;
		int    n;
		repeat (12) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// directed: gate order, window entry and exit, extremes
		send(mk(1, 0, 0, 0, 16384, 0, 0, 0, 0, 0, 0));               // no target yet
		send(mk(1, 0, 0, 0, 16384, 0, 0, 0, 1, 0, 0));               // variance above stored zero
		send(mk(0, 0, 0, 0, 16384, 0, 0, 0, '1, '1, '1));
		send(mk(1, 0, 0, 0, 16384, 0, 0, 0, '1, '1, '1));            // on target: aligning
		send(mk(1, 1, -1, 0, 0, 16384, 0, 0, 5, 6, 7));              // inside outer window
		send(mk(1, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 16384, 0, 0, 0, 0, 0, 0));
		send(mk(1, 32'h80000000, 32'h80000000, 32'h80000000, -32768, 32767, -32768, 32767,
			0, 0, 0));
		send(mk(1, 65536, 0, 0, 0, 0, 0, 0, 0, 0, 0));               // zero quaternion
		send(mk(1, -65536, 1, 0, 11585, 0, 0, 11585, 0, 0, 0));      // target behind, big turn
		send(mk(0, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 0, 0, 0, 16384, 0, 0, 0));
		send(mk(1, 32'h80000000, 32'h80000000, 32'h80000000, 16384, 0, 0, 0, 0, 0, 0));
		send(mk(1, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 16384, 0, 0, 0, 0, 0, 0));
		send(mk(0, 1000, 2000, 3000, 11585, 0, 0, 11585, 32'h10000, 32'h10000, 32'h10000));
		send(mk(1, 1000, 2000, 3000, 16384, 0, 0, 0, 32'h10000, 0, 0)); // align from quats
		send(mk(1, 31000, 2000, 3000, -16384, 0, 0, 0, 0, 0, 0));    // inside the inner window
		send(mk(1, 1000, 2000, 3000, 0, 0, 0, 16384, 32'h10001, 0, 0)); // gate holds aligning
		send(mk(1, 32'h70000, 2000, 3000, 16384, 0, 0, 0, 0, 0, 0)); // leaves outer window
		send(mk(1, 32'h7000, 2000, 3000, -16384, -1, -1, -1, 1, 1, 1));

		// register settings, extremes among them
		for (int ph = 0; ph < 6; ph++) begin
			if (ph > 0) begin
				in_valid <= 0;
				wait_drained();
				repeat (SETTLE) @(posedge clk);
				case (ph)
					1: begin
						reg_write(REG_STOP, 0); reg_write(REG_TVG, 16'hffff);
						reg_write(REG_RVG, 16'hffff); reg_write(REG_HYST, 256);
					end
					2: begin
						reg_write(REG_STOP, 25736); reg_write(REG_TVG, 0);
						reg_write(REG_RVG, 0); reg_write(REG_HYST, 16'hffff);
					end
					3: begin
						reg_write(REG_STOP, 32'hffff_ffff); reg_write(REG_HYST, 0);
						reg_write(REG_TVG, 32'hffff_0100); reg_write(REG_RVG, 32'h0001_0080);
					end
					default: begin
						reg_write(REG_STOP, $urandom()); reg_write(REG_TVG, $urandom());
						reg_write(REG_RVG, $urandom());
						reg_write(REG_HYST, $urandom_range(256, 65535));
					end
				endcase
			end
			n = (ph == 0) ? 50 : 70;
			for (int i = 0; i < n; i++) begin
				calm = (ph == 2 && i >= 10 && i < 50);   // long stretch with no idling
				if (ph == 3 && i == 35) begin           // sender holds off until drained
					in_valid <= 0;
					wait_drained();
				end
				p = rand_item();
				send(p);
			end
			calm = 0;
		end
		in_valid <= 0;

		wait_drained();
		repeat (SETTLE) @(posedge clk);
		if (sb.cmd_q.size() != 0) begin
			$error("%0d commands never arrived", sb.cmd_q.size());
			sb.errors++;
		end
		if (sb.errors == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule
